[rtl/afpt_pkg.sv]
// Package for the AABB frustum plane test block.
// Holds field widths, result codes and the structs passed between cells.
// No dependencies.
package afpt_pkg;

    localparam int MAX_PLANES = 6;
    localparam int COORD_W    = 24;
    localparam int COEF_W     = 12;
    localparam int D_W        = 28;
    localparam int PROD_W     = COEF_W + COORD_W;
    localparam int ACC_W      = 40;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = 64;
    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        CLS_INSIDE    = 2'd0,
        CLS_OUTSIDE   = 2'd1,
        CLS_INTERSECT = 2'd2
    } cls_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  index;
        logic [CFG_W-1:0]  data;
    } cfg_wr_t;

    // Item state carried down the cell chain.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] lo;
        logic [2:0][COORD_W-1:0] hi;
        logic [MAX_PLANES-1:0]   en;
        logic [IDX_W-1:0]        hint;
        logic                    hint_rej;
        logic                    rej_found;
        logic [IDX_W-1:0]        rej_idx;
        logic [MAX_PLANES-1:0]   mask;
    } token_t;

endpackage

[rtl/afpt_cell.sv]
// One plane cell of the frustum test chain: holds one plane register,
// forms the p/n vertex dot products and updates the running item state.
// Depends on afpt_pkg.
module afpt_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  afpt_pkg::cfg_wr_t cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  afpt_pkg::token_t  in_tok,
    output logic              out_valid,
    input  logic              out_ready,
    output afpt_pkg::token_t  out_tok
);

    localparam logic [afpt_pkg::IDX_W-1:0] MY_IDX = afpt_pkg::IDX_W'(CELL_IDX);
    localparam int PW = afpt_pkg::PROD_W;
    localparam int AW = afpt_pkg::ACC_W;

    logic [afpt_pkg::CFG_W-1:0]             plane_reg;
    logic [2:0][afpt_pkg::COEF_W-1:0]       coef;
    logic [afpt_pkg::D_W-1:0]               d_val;

    logic                                   a_valid_reg, a_valid_next;
    afpt_pkg::token_t                       a_tok_reg;
    logic [2:0][PW-1:0]                     a_pp_reg, a_pp_next;
    logic [2:0][PW-1:0]                     a_np_reg, a_np_next;

    logic                                   b_valid_reg, b_valid_next;
    afpt_pkg::token_t                       b_tok_reg, b_tok_next;

    logic                                   ready_a, ready_b;
    logic [AW-1:0]                          sp_sum, sn_sum, d_ext;
    logic                                   tested, is_out, is_cross;

    assign coef  = plane_reg[3*afpt_pkg::COEF_W-1:0];
    assign d_val = plane_reg[afpt_pkg::CFG_W-1:3*afpt_pkg::COEF_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
        end else if (cfg.we && cfg.index == MY_IDX) begin
            plane_reg <= cfg.data;
        end
    end

    assign ready_b  = !b_valid_reg || out_ready;
    assign ready_a  = !a_valid_reg || ready_b;
    assign in_ready = ready_a;

    // Stage A: vertex select by normal sign, then multiply.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (coef[k][afpt_pkg::COEF_W-1]) begin
                a_pp_next[k] = PW'({{(PW-afpt_pkg::COEF_W){coef[k][afpt_pkg::COEF_W-1]}}, coef[k]}
                    * {{(PW-afpt_pkg::COORD_W){in_tok.lo[k][afpt_pkg::COORD_W-1]}}, in_tok.lo[k]});
                a_np_next[k] = PW'({{(PW-afpt_pkg::COEF_W){coef[k][afpt_pkg::COEF_W-1]}}, coef[k]}
                    * {{(PW-afpt_pkg::COORD_W){in_tok.hi[k][afpt_pkg::COORD_W-1]}}, in_tok.hi[k]});
            end else begin
                a_pp_next[k] = PW'({{(PW-afpt_pkg::COEF_W){coef[k][afpt_pkg::COEF_W-1]}}, coef[k]}
                    * {{(PW-afpt_pkg::COORD_W){in_tok.hi[k][afpt_pkg::COORD_W-1]}}, in_tok.hi[k]});
                a_np_next[k] = PW'({{(PW-afpt_pkg::COEF_W){coef[k][afpt_pkg::COEF_W-1]}}, coef[k]}
                    * {{(PW-afpt_pkg::COORD_W){in_tok.lo[k][afpt_pkg::COORD_W-1]}}, in_tok.lo[k]});
            end
        end
    end

    always_comb begin
        a_valid_next = ready_a ? in_valid : a_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_a && in_valid) begin
            a_tok_reg <= in_tok;
            a_pp_reg  <= a_pp_next;
            a_np_reg  <= a_np_next;
        end
    end

    // Stage B: sum with d * 2^10, classify, fold into item state.
    always_comb begin
        d_ext  = {{(AW-afpt_pkg::D_W-10){d_val[afpt_pkg::D_W-1]}}, d_val, 10'd0};
        sp_sum = d_ext
               + {{(AW-PW){a_pp_reg[0][PW-1]}}, a_pp_reg[0]}
               + {{(AW-PW){a_pp_reg[1][PW-1]}}, a_pp_reg[1]}
               + {{(AW-PW){a_pp_reg[2][PW-1]}}, a_pp_reg[2]};
        sn_sum = d_ext
               + {{(AW-PW){a_np_reg[0][PW-1]}}, a_np_reg[0]}
               + {{(AW-PW){a_np_reg[1][PW-1]}}, a_np_reg[1]}
               + {{(AW-PW){a_np_reg[2][PW-1]}}, a_np_reg[2]};
        tested   = a_tok_reg.en[CELL_IDX];
        is_out   = tested && sp_sum[AW-1];
        is_cross = tested && !sp_sum[AW-1] && sn_sum[AW-1];

        b_tok_next = a_tok_reg;
        if (is_out) begin
            if (a_tok_reg.hint == MY_IDX) begin
                b_tok_next.hint_rej = 1'b1;
            end else if (!a_tok_reg.rej_found) begin
                b_tok_next.rej_found = 1'b1;
                b_tok_next.rej_idx   = MY_IDX;
            end
        end
        if (is_cross) begin
            b_tok_next.mask[CELL_IDX] = 1'b1;
        end
        b_valid_next = ready_b ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_b && a_valid_reg) begin
            b_tok_reg <= b_tok_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_tok   = b_tok_reg;

endmodule

[rtl/aabb_frustum_plane_test_unit.sv]
// Top level of the AABB frustum plane test: a chain of plane cells and an
// output register that forms classification, straddle mask and next hint.
// Depends on afpt_pkg and afpt_cell.
//
//   channel   dir  handshake          payload
//   s_        in   s_tvalid/s_tready  box corners, plane enable, hint
//   m_        out  m_tvalid/m_tready  classification, mask, next hint
//   cfg_      in   cfg_we             plane register index and data
//
// One item per cycle unless m_tready stalls the output. Each plane cell
// registers a multiply stage, then a sum and classify stage; an output
// register follows the chain. Each stage holds its transfer only while the
// next one is full and stalled, so bubbles collapse under back pressure.
// Synchronous active-low reset clears all valid bits and plane registers.
module aabb_frustum_plane_test_unit #(
    parameter int PLANE_COUNT = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // plane_enable, hint_plane, zero fill
    input  logic [afpt_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // classification, out_mask, next_hint_plane, zero fill
    output logic [afpt_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               cfg_we,
    input  logic [afpt_pkg::IDX_W-1:0]         cfg_index,
    input  logic [afpt_pkg::CFG_W-1:0]         cfg_data
);

    localparam int NCELL = (PLANE_COUNT < afpt_pkg::MAX_PLANES) ?
                           PLANE_COUNT : afpt_pkg::MAX_PLANES;
    localparam int CW    = afpt_pkg::COORD_W;

    afpt_pkg::cfg_wr_t  cfg;
    afpt_pkg::token_t   tok   [NCELL+1];
    logic               vld   [NCELL+1];
    logic               rdy   [NCELL+1];

    logic                                 out_valid_reg, out_valid_next;
    logic [afpt_pkg::OUT_DATA_W-1:0]      out_data_reg, out_data_next;
    afpt_pkg::token_t                     last_tok;
    afpt_pkg::cls_t                       cls;
    logic [afpt_pkg::MAX_PLANES-1:0]      mask;
    logic [afpt_pkg::IDX_W-1:0]           nh;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    always_comb begin
        tok[0]           = '0;
        tok[0].lo[0]     = s_tdata[CW-1:0];
        tok[0].lo[1]     = s_tdata[2*CW-1:CW];
        tok[0].lo[2]     = s_tdata[3*CW-1:2*CW];
        tok[0].hi[0]     = s_tdata[4*CW-1:3*CW];
        tok[0].hi[1]     = s_tdata[5*CW-1:4*CW];
        tok[0].hi[2]     = s_tdata[6*CW-1:5*CW];
        tok[0].en        = s_tdata[6*CW+afpt_pkg::MAX_PLANES-1:6*CW];
        tok[0].hint      = s_tdata[6*CW+afpt_pkg::MAX_PLANES+afpt_pkg::IDX_W-1:
                                   6*CW+afpt_pkg::MAX_PLANES];
    end

    assign vld[0]   = s_tvalid;
    assign s_tready = rdy[0];

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        afpt_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cfg       (cfg),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .in_tok    (tok[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .out_tok   (tok[i+1])
        );
    end

    assign last_tok   = tok[NCELL];
    assign rdy[NCELL] = !out_valid_reg || m_tready;

    always_comb begin
        if (last_tok.hint_rej) begin
            cls  = afpt_pkg::CLS_OUTSIDE;
            mask = '0;
            nh   = last_tok.hint;
        end else if (last_tok.rej_found) begin
            cls  = afpt_pkg::CLS_OUTSIDE;
            mask = '0;
            nh   = last_tok.rej_idx;
        end else begin
            cls  = (last_tok.mask != '0) ? afpt_pkg::CLS_INTERSECT : afpt_pkg::CLS_INSIDE;
            mask = last_tok.mask;
            nh   = ({1'b0, last_tok.hint} < (afpt_pkg::IDX_W+1)'(PLANE_COUNT)) ?
                   last_tok.hint : '0;
        end
        out_data_next  = {{(afpt_pkg::OUT_DATA_W-11){1'b0}}, nh, mask, cls};
        out_valid_next = rdy[NCELL] ? vld[NCELL] : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[NCELL] && vld[NCELL]) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_outside_no_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == afpt_pkg::CLS_OUTSIDE) |-> (m_tdata[7:2] == '0))
        else $error("outside result carries a straddle mask");

    a_mask_iff_cross: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[7:2] != '0) == (m_tdata[1:0] == afpt_pkg::CLS_INTERSECT)))
        else $error("straddle mask and intersect class disagree");

    a_hint_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[10:8]} < (afpt_pkg::IDX_W+1)'(PLANE_COUNT)))
        else $error("next hint plane out of range");

endmodule
